// File: sv/two_hand_start_supervisor_assert.svh
// Assertion macros shared by the two-hand start supervisor checker.
// Depends on nothing; the files that use it include it by its bare name.
`ifndef TWO_HAND_START_SUPERVISOR_ASSERT_SVH
`define TWO_HAND_START_SUPERVISOR_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent, outside reset.
`define THS_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
   lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
      else $error(msg);

// Consequence must hold in the cycle after the antecedent, outside reset.
`define THS_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
   lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
      else $error(msg);

// Checked also while reset is high.
`define THS_ASSERT_ALWAYS(lbl, ck, ante, cons, msg) \
   lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/ths_pkg.sv
// Package of the two-hand start supervisor: request and response types,
// status codes, register indexes and reset values. Depends on nothing.
package ths_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;
   localparam int unsigned WindowWidth   = 16;
   localparam int unsigned TotalWidth    = 24;

   // Register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_TWO_BUTTON_MODE = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESSED_LEVEL_A = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PRESSED_LEVEL_B = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_WINDOW_TICKS    = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_TOTAL_TICKS     = 3'd4;

   // Register reset values.
   localparam logic                   RST_TWO_BUTTON_MODE = 1'b1;
   localparam logic                   RST_PRESSED_LEVEL_A = 1'b1;
   localparam logic                   RST_PRESSED_LEVEL_B = 1'b1;
   localparam logic [WindowWidth-1:0] RST_WINDOW_TICKS    = 16'd200;
   localparam logic [TotalWidth-1:0]  RST_TOTAL_TICKS     = 24'd600000;

   localparam logic [WindowWidth-1:0] WINDOW_MAX = '1;
   localparam logic [TotalWidth-1:0]  TOTAL_MAX  = '1;

   // Response status codes.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_RELEASE = 3'd1;
   localparam logic [2:0] ST_ARMED   = 3'd2;
   localparam logic [2:0] ST_SUCCESS = 3'd3;
   localparam logic [2:0] ST_TERM    = 3'd4;
   localparam logic [2:0] ST_TIMEOUT = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RELEASE,
      PH_ARMED
   } phase_type;

   typedef struct packed {
      logic start_attempt;
      logic level_a;
      logic level_b;
      logic read_ok_a;
      logic read_ok_b;
      logic abort_request;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       finished;
   } rsp_type;

endpackage

// File: sv/two_hand_start_supervisor.sv
// Two-hand start supervisor: top level with the attempt state machine.
// Depends on ths_pkg.
//
// Usage. Each request on the req_ channel is one poll tick: the button
// levels, their read-valid bits, an abort and a start strobe. For every
// request exactly one response leaves on the rsp_ channel, carrying the
// attempt status and a finished flag that is high only on the tick the
// attempt ends (success, terminated or total timeout). Both channels use
// valid/ready handshakes.
// A request is taken into an input register, and its response moves into
// the output register when the output stage can move, raising rsp_valid.
// The state update is a single pass of short logic (one 16-bit and one
// 24-bit compare and increment), so one request per cycle is sustained
// while the receiver keeps rsp_ready high.
// If the receiver stalls, the waiting response holds and one further
// request can still be taken into the input register; only then does
// req_ready fall.
// Synchronous reset returns the attempt to idle, clears all timers and both
// pipeline stages, and loads the register defaults (two-button mode,
// active-high buttons, 200 window ticks, 600000 total ticks). The csr_ port
// writes a register. The user must use it only while idle; not enforced.
module two_hand_start_supervisor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ths_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ths_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [ths_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [ths_pkg::CsrDataWidth-1:0]     csr_wdata
);

   // Configuration registers.
   logic                               mode_ff;
   logic                               lvl_a_ff;
   logic                               lvl_b_ff;
   logic [ths_pkg::WindowWidth-1:0]    window_ticks_ff;
   logic [ths_pkg::TotalWidth-1:0]     total_ticks_ff;

   // Pipeline registers.
   logic                               in_valid_ff, in_valid_in;
   ths_pkg::req_type                   in_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   ths_pkg::rsp_type                   rsp_ff, rsp_in;

   // Attempt state.
   ths_pkg::phase_type                 phase_ff, phase_in;
   logic                               win_open_ff, win_open_in;
   logic [ths_pkg::WindowWidth-1:0]    win_count_ff, win_count_in;
   logic                               exp_wait_ff, exp_wait_in;
   logic [ths_pkg::TotalWidth-1:0]     total_count_ff, total_count_in;

   // Results of one tick's step, before the pipeline decides to commit it.
   ths_pkg::phase_type                 ph_eff;
   ths_pkg::phase_type                 ph_step;
   logic                               wo_step;
   logic [ths_pkg::WindowWidth-1:0]    wc_step;
   logic                               exp_step;
   logic [ths_pkg::TotalWidth-1:0]     tc_step;
   logic                               ended;
   logic [2:0]                         end_code;

   logic                               advance;
   logic                               fire;
   logic                               req_accept;

   // The output stage moves when it is empty or being emptied; the input
   // stage feeds it whenever it holds a request and the output can move.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign fire       = in_valid_ff && advance;
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ths_pkg::RST_TWO_BUTTON_MODE;
         lvl_a_ff        <= ths_pkg::RST_PRESSED_LEVEL_A;
         lvl_b_ff        <= ths_pkg::RST_PRESSED_LEVEL_B;
         window_ticks_ff <= ths_pkg::RST_WINDOW_TICKS;
         total_ticks_ff  <= ths_pkg::RST_TOTAL_TICKS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ths_pkg::CSR_TWO_BUTTON_MODE: mode_ff  <= csr_wdata[0];
            ths_pkg::CSR_PRESSED_LEVEL_A: lvl_a_ff <= csr_wdata[0];
            ths_pkg::CSR_PRESSED_LEVEL_B: lvl_b_ff <= csr_wdata[0];
            ths_pkg::CSR_WINDOW_TICKS:
               window_ticks_ff <= csr_wdata[ths_pkg::WindowWidth-1:0];
            ths_pkg::CSR_TOTAL_TICKS:
               total_ticks_ff <= csr_wdata[ths_pkg::TotalWidth-1:0];
            default: ;
         endcase
      end
   end

   // One tick of the supervisor. A start strobe first clears the attempt
   // and puts it in the release wait; the same tick is then processed.
   // Order within the tick: abort, then the phase step, then the total limit.
   always_comb begin
      logic two;
      logic pa;
      logic pb;
      logic any;
      logic success;
      logic wo_eff;
      logic [ths_pkg::WindowWidth-1:0] wc_eff;
      logic exp_eff;
      logic [ths_pkg::TotalWidth-1:0] tc_eff;

      two = mode_ff;
      pa  = in_ff.read_ok_a && (in_ff.level_a == lvl_a_ff);
      pb  = two && in_ff.read_ok_b && (in_ff.level_b == lvl_b_ff);
      any = pa || pb;

      ph_eff  = in_ff.start_attempt ? ths_pkg::PH_RELEASE : phase_ff;
      wo_eff  = in_ff.start_attempt ? 1'b0 : win_open_ff;
      wc_eff  = in_ff.start_attempt ? '0 : win_count_ff;
      exp_eff = in_ff.start_attempt ? 1'b0 : exp_wait_ff;
      tc_eff  = in_ff.start_attempt ? '0 : total_count_ff;

      ph_step  = ph_eff;
      wo_step  = wo_eff;
      wc_step  = wc_eff;
      exp_step = exp_eff;
      success  = 1'b0;
      ended    = 1'b0;
      end_code = ths_pkg::ST_IDLE;

      if (ph_eff == ths_pkg::PH_RELEASE) begin
         // Arm once every configured button reads cleanly and is released.
         if (in_ff.read_ok_a && (!two || in_ff.read_ok_b) && !any) begin
            ph_step = ths_pkg::PH_ARMED;
         end
      end else if (ph_eff == ths_pkg::PH_ARMED) begin
         if (!two) begin
            success = pa;
         end else if (exp_eff) begin
            // After an expiry, refuse until both buttons are let go.
            if (!any) begin
               exp_step = 1'b0;
            end
         end else begin
            if (any && !wo_eff) begin
               wo_step = 1'b1;
               wc_step = '0;
            end
            if (wo_step) begin
               if (wc_step >= window_ticks_ff) begin
                  wo_step  = 1'b0;
                  wc_step  = '0;
                  exp_step = any;
               end else begin
                  success = pa && pb;
                  if (wc_step != ths_pkg::WINDOW_MAX) begin
                     wc_step = wc_step + 1'b1;
                  end
               end
            end
         end
      end

      tc_step = (tc_eff != ths_pkg::TOTAL_MAX) ? tc_eff + 1'b1 : tc_eff;

      if (ph_eff != ths_pkg::PH_IDLE) begin
         if (in_ff.abort_request) begin
            ended    = 1'b1;
            end_code = ths_pkg::ST_TERM;
         end else if (success) begin
            ended    = 1'b1;
            end_code = ths_pkg::ST_SUCCESS;
         end else if (tc_step >= total_ticks_ff) begin
            ended    = 1'b1;
            end_code = ths_pkg::ST_TIMEOUT;
         end
      end
   end

   // Next state: committed only when the tick moves to the output stage.
   always_comb begin
      phase_in       = phase_ff;
      win_open_in    = win_open_ff;
      win_count_in   = win_count_ff;
      exp_wait_in    = exp_wait_ff;
      total_count_in = total_count_ff;
      if (fire) begin
         if (ended || (ph_eff == ths_pkg::PH_IDLE)) begin
            phase_in       = ths_pkg::PH_IDLE;
            win_open_in    = 1'b0;
            win_count_in   = '0;
            exp_wait_in    = 1'b0;
            total_count_in = '0;
         end else begin
            phase_in       = ph_step;
            win_open_in    = wo_step;
            win_count_in   = wc_step;
            exp_wait_in    = exp_step;
            total_count_in = tc_step;
         end
      end
   end

   // Response of the tick.
   always_comb begin
      rsp_in.finished = ended;
      if (ended) begin
         rsp_in.status = end_code;
      end else begin
         unique case (ph_step)
            ths_pkg::PH_RELEASE: rsp_in.status = ths_pkg::ST_RELEASE;
            ths_pkg::PH_ARMED:   rsp_in.status = ths_pkg::ST_ARMED;
            default:             rsp_in.status = ths_pkg::ST_IDLE;
         endcase
      end
   end

   // Handshake bookkeeping of the two stages.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         phase_ff       <= ths_pkg::PH_IDLE;
         win_open_ff    <= 1'b0;
         win_count_ff   <= '0;
         exp_wait_ff    <= 1'b0;
         total_count_ff <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         phase_ff       <= phase_in;
         win_open_ff    <= win_open_in;
         win_count_ff   <= win_count_in;
         exp_wait_ff    <= exp_wait_in;
         total_count_ff <= total_count_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: sv/ths_checker.sv
// Port-level checker of the two-hand start supervisor and its bind.
// Depends on ths_pkg and two_hand_start_supervisor_assert.svh.
`include "two_hand_start_supervisor_assert.svh"

module ths_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input ths_pkg::rsp_type                  rsp_data
);

   logic ends_code;
   assign ends_code = (rsp_data.status == ths_pkg::ST_SUCCESS) ||
                      (rsp_data.status == ths_pkg::ST_TERM) ||
                      (rsp_data.status == ths_pkg::ST_TIMEOUT);

   `THS_ASSERT_NOW(a_finished_matches_status, clock, reset, rsp_valid, rsp_data.finished == ends_code, "finished flag disagrees with status")

   `THS_ASSERT_NOW(a_status_legal, clock, reset, rsp_valid, rsp_data.status <= ths_pkg::ST_TIMEOUT, "status code out of range")

   `THS_ASSERT_ALWAYS(a_reset_empties_output, clock, reset, !rsp_valid, "response valid after reset")

   `THS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")

   `THS_ASSERT_NOW(a_ready_low_only_when_stalled, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request port stalled without a waiting response")

endmodule

bind two_hand_start_supervisor ths_checker u_ths_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_data     (rsp_data)
);
